// ===== rtl/core/art_pkg.sv =====
package art_pkg;

   // table depth default
   localparam int MAX_REGIONS_DEF = 16;

   // request function codes
   localparam logic [1:0] FUNC_ADD  = 2'd0;
   localparam logic [1:0] FUNC_FIND = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_MISS    = 2'd2;

   // command queue depth between front and back
   localparam int Q_DEPTH = 2;
   localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int QF_W    = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] region_base;
      logic [63:0] region_size;
      logic [31:0] region_flags;
      logic [63:0] lookup_address;
      logic [3:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  entry_id;
      logic [63:0] entry_base;
      logic [63:0] entry_size;
      logic [31:0] entry_flags;
      logic [4:0]  region_count;
   } rsp_type;

   // classified operation
   typedef enum logic [2:0] {
      OP_ADD,
      OP_ADD_ZERO,
      OP_FIND,
      OP_READ,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] region_base;
      logic [63:0] region_size;
      logic [31:0] region_flags;
      logic [63:0] lookup_address;
      logic [3:0]  entry_index;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // one stored region
   typedef struct packed {
      logic [63:0] base;
      logic [63:0] size;
      logic [31:0] flags;
   } entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_DONE
   } back_state_type;

endpackage

// ===== rtl/core/art_ram.sv =====
module art_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/art_front.sv =====
module art_front import art_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req,
   output logic       push,
   output cmd_type    push_cmd,
   input  q_stat_type q_stat
);

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_ff, hold_in;
   logic    load;

   // hold one request until the queue takes it
   assign push      = hold_valid_ff && !q_stat.full;
   assign req_stall = hold_valid_ff && q_stat.full;
   assign load      = req_valid && !req_stall;
   assign push_cmd  = hold_ff;

   // classify the incoming request
   always_comb begin
      hold_valid_in = load || (hold_valid_ff && !push);
      hold_in       = hold_ff;
      if (load) begin
         hold_in.region_base    = req.region_base;
         hold_in.region_size    = req.region_size;
         hold_in.region_flags   = req.region_flags;
         hold_in.lookup_address = req.lookup_address;
         hold_in.entry_index    = req.entry_index;
         case (req.func)
            FUNC_ADD: begin
               hold_in.op = (req.region_size == 64'd0) ? OP_ADD_ZERO : OP_ADD;
            end
            FUNC_FIND: begin
               hold_in.op = OP_FIND;
            end
            FUNC_READ: begin
               hold_in.op = OP_READ;
            end
            default: begin
               hold_in.op = OP_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

// ===== rtl/core/art_queue.sv =====
module art_queue import art_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cmd_type    push_cmd,
   input  logic       pop,
   output cmd_type    head,
   output q_stat_type q_stat
);

   cmd_type          entries_ff [Q_DEPTH];
   logic [QP_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QF_W-1:0]  fill_ff, fill_in;

   assign head         = entries_ff[rd_ptr_ff];
   assign q_stat.full  = (fill_ff == QF_W'(Q_DEPTH));
   assign q_stat.empty = (fill_ff == '0);

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + QP_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + QP_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + QF_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QF_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/art_back.sv =====
module art_back import art_pkg::*; #(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   output logic       pop,
   input  cmd_type    head,
   input  q_stat_type q_stat,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp
);

   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam int CMP_W = CNT_W + IDX_W + 4;
   localparam int ENT_W = $bits(entry_type);

   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [63:0]      addr_ff, addr_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [ENT_W-1:0] rd_raw;
   entry_type        rd_entry;
   logic [63:0]      end_addr;
   logic             hit;
   logic [CMP_W-1:0] count_cmp;
   logic [CMP_W-1:0] idx_cmp;
   logic [CMP_W-1:0] scan_next_cmp;

   art_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_REGIONS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = entry_type'(rd_raw);

   // range test on the entry read last cycle, end wraps at 64 bits
   assign end_addr = rd_entry.base + rd_entry.size;
   assign hit      = (addr_ff >= rd_entry.base) && (addr_ff < end_addr);

   assign count_cmp     = CMP_W'(count_ff);
   assign idx_cmp       = CMP_W'(head.entry_index);
   assign scan_next_cmp = CMP_W'(scan_ff) + CMP_W'(1);

   assign wr_entry.base  = head.region_base;
   assign wr_entry.size  = head.region_size;
   assign wr_entry.flags = head.region_flags;
   assign wr_addr        = IDX_W'(count_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // sequencer: execute, read or scan, deliver
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      addr_in      = addr_ff;
      res_in       = res_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = scan_ff + IDX_W'(1);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               res_in   = '0;
               state_in = S_DONE;
               case (head.op)
                  OP_ADD: begin
                     if (count_ff == CNT_W'(MAX_REGIONS)) begin
                        res_in.status = ST_REFUSED;
                     end else begin
                        wr_en           = 1'b1;
                        count_in        = count_ff + CNT_W'(1);
                        res_in.status   = ST_OK;
                        res_in.entry_id = 4'(count_ff);
                     end
                  end
                  OP_ADD_ZERO: begin
                     res_in.status = ST_REFUSED;
                  end
                  OP_READ: begin
                     if (idx_cmp < count_cmp) begin
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(head.entry_index);
                        scan_in  = IDX_W'(head.entry_index);
                        state_in = S_READ;
                     end else begin
                        res_in.status = ST_MISS;
                     end
                  end
                  OP_FIND: begin
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        scan_in  = '0;
                        addr_in  = head.lookup_address;
                        state_in = S_SCAN;
                     end else begin
                        res_in.status = ST_MISS;
                     end
                  end
                  default: begin
                     res_in.status = ST_MISS;
                  end
               endcase
            end
         end
         S_READ: begin
            res_in.status      = ST_OK;
            res_in.entry_id    = 4'(scan_ff);
            res_in.entry_base  = rd_entry.base;
            res_in.entry_size  = rd_entry.size;
            res_in.entry_flags = rd_entry.flags;
            state_in           = S_DONE;
         end
         S_SCAN: begin
            if (hit) begin
               res_in.status      = ST_OK;
               res_in.entry_id    = 4'(scan_ff);
               res_in.entry_base  = rd_entry.base;
               res_in.entry_size  = rd_entry.size;
               res_in.entry_flags = rd_entry.flags;
               state_in           = S_DONE;
            end else if (scan_next_cmp < count_cmp) begin
               rd_en   = 1'b1;
               scan_in = scan_ff + IDX_W'(1);
            end else begin
               res_in        = '0;
               res_in.status = ST_MISS;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = res_ff;
               rsp_in.region_count = 5'(count_ff);
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      addr_ff <= addr_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ===== rtl/core/address_region_table.sv =====
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_type: func, region, address, index
// rsp       out        rsp_valid/rsp_stall  rsp_type: status, entry, region_count
//
// add, refused and bad requests pass the front register, the command queue and then the
// execute and deliver states to rsp_valid; a read also passes S_READ. A find compares up to
// MAX_REGIONS entries in S_SCAN, one compare per cycle on the single region memory read port.
// synchronous reset clears the count, the queue and the valid flags; memory is not cleared.
// req is taken while a result waits under rsp_stall, until the front register and the
// two-entry command queue fill.
module address_region_table import art_pkg::*; #(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   logic       push;
   cmd_type    push_cmd;
   logic       pop;
   cmd_type    head;
   q_stat_type q_stat;

   // accept and classify
   art_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .push      (push),
      .push_cmd  (push_cmd),
      .q_stat    (q_stat)
   );

   // decoupling queue
   art_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   // table execution
   art_back #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

// ===== rtl/core/art_checker.sv =====
module art_checker import art_pkg::*; #(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result changed");

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_REFUSED ||
                    rsp.status == ST_MISS)
      else $error("undefined status code");

   // refused and missed requests carry an empty entry
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != ST_OK |->
         rsp.entry_id == 4'd0 && rsp.entry_base == 64'd0 &&
         rsp.entry_size == 64'd0 && rsp.entry_flags == 32'd0)
      else $error("failed result with entry data");

   // count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (MAX_REGIONS > 31) || (rsp.region_count <= 5'(MAX_REGIONS)))
      else $error("region count beyond table depth");

   // a success means at least one region is held
   a_ok_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == ST_OK |-> (MAX_REGIONS > 31) || rsp.region_count != 5'd0)
      else $error("success with empty table");

endmodule

bind address_region_table art_checker #(
   .MAX_REGIONS (MAX_REGIONS)
) u_art_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);
